// File: hw/rtl/cell_voltage_frame_receiver_defines.svh
// assertion macros shared by the checker
`ifndef CELL_VOLTAGE_FRAME_RECEIVER_DEFINES_SVH
`define CELL_VOLTAGE_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CVFR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cvfr check failed");

// next-cycle implication, disabled during reset
`define CVFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cvfr check failed");

`endif

// File: hw/rtl/cvfr_pkg.sv
package cvfr_pkg;

   localparam int NUM_GROUPS  = 9;
   localparam int FRAME_BYTES = 8;
   localparam int PAYLOAD_LEN = 6;
   localparam int READINGS    = 4;

   localparam int POS_W   = $clog2(FRAME_BYTES);
   localparam int BYTE_W  = 8;
   localparam int CRC_W   = 16;
   localparam int RAW_W   = 12;
   localparam int VOLT_W  = 13;
   localparam int INDEX_W = 6;
   localparam int GROUP_W = 4;
   localparam int K_W     = $clog2(READINGS);

   localparam logic [CRC_W-1:0] PEC_POLY = 16'h4599;
   localparam logic [CRC_W-1:0] PEC_SEED = 16'd16;

   localparam logic [POS_W-1:0] POS_FIRST    = '0;
   localparam logic [POS_W-1:0] POS_PEC_HIGH = POS_W'(PAYLOAD_LEN);
   localparam logic [POS_W-1:0] POS_PEC_LOW  = POS_W'(FRAME_BYTES - 1);

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_PEC_ERROR = 1'b1
   } status_type;

   typedef struct packed {
      status_type                         status;
      logic [GROUP_W-1:0]                 group;
      logic [READINGS-1:0][RAW_W-1:0]     raw;
   } frame_rec_type;

   function automatic logic [CRC_W-1:0] pec_table_entry(input logic [BYTE_W-1:0] idx);
      logic [CRC_W-1:0] r;
      r = {1'b0, idx, 7'b0};
      for (int b = 0; b < BYTE_W; b++) begin
         if (r[14]) begin
            r = {r[14:0], 1'b0} ^ PEC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [CRC_W-1:0] pec_byte_step(input logic [CRC_W-1:0] rem,
                                                      input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] addr;
      addr = rem[14:7] ^ data;
      return {rem[7:0], 8'b0} ^ pec_table_entry(addr);
   endfunction

   // reading * 3 / 2, rounded toward zero
   function automatic logic signed [VOLT_W-1:0] scale_reading(input logic [RAW_W-1:0] raw);
      logic [VOLT_W:0] t;
      t = {{2{raw[RAW_W-1]}}, raw} + {raw[RAW_W-1], raw, 1'b0};
      if (t[VOLT_W] && t[0]) begin
         t = t + 14'd1;
      end
      return signed'(t[VOLT_W:1]);
   endfunction

endpackage

// File: hw/rtl/cvfr_req_if.sv
interface cvfr_req_if;
   logic                              valid;
   logic                              ready;
   logic [cvfr_pkg::BYTE_W-1:0]       rx_byte;
   logic [cvfr_pkg::GROUP_W-1:0]      group_index;
   logic                              frame_start;

   modport source (output valid, output rx_byte, output group_index, output frame_start,
                   input ready);
   modport sink   (input valid, input rx_byte, input group_index, input frame_start,
                   output ready);
endinterface

// File: hw/rtl/cvfr_rsp_if.sv
interface cvfr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 result_status;
   logic [cvfr_pkg::INDEX_W-1:0]         cell_index;
   logic signed [cvfr_pkg::VOLT_W-1:0]   cell_voltage;
   logic                                 last_of_run;

   modport source (output valid, output result_status, output cell_index,
                   output cell_voltage, output last_of_run, input ready);
   modport sink   (input valid, input result_status, input cell_index,
                   input cell_voltage, input last_of_run, output ready);
endinterface

// File: hw/rtl/cell_voltage_frame_receiver.sv
// Receives 8-byte cell-voltage readback frames one word per cycle: six payload bytes,
// then the two PEC bytes. A table-driven CRC15 byte step keeps up with one byte every
// clock, so req_chan takes a word each cycle while the result queue has room. The
// last byte of a frame leaves a frame record in a two-entry result queue; once it
// heads the queue, rsp_chan shows four cell readings (scaled by 1.5, one word per
// cycle while rsp_chan.ready is high) or a single error word when the PEC or the
// group number is bad. req_chan.ready drops only while two frames wait undrained.
// frame_start on any byte restarts a frame.
module cell_voltage_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   cvfr_req_if.sink   req_chan,
   cvfr_rsp_if.source rsp_chan
);

   logic                     accept;
   logic                     push;
   logic                     full;
   cvfr_pkg::frame_rec_type  push_rec;

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && req_chan.ready;

   cvfr_frame_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_chan.rx_byte),
      .group_index (req_chan.group_index),
      .frame_start (req_chan.frame_start),
      .push        (push),
      .push_rec    (push_rec)
   );

   cvfr_result_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (full),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hw/rtl/cvfr_frame_unpack.sv
module cvfr_frame_unpack (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [cvfr_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [cvfr_pkg::GROUP_W-1:0]   group_index,
   input  logic                           frame_start,
   output logic                           push,
   output cvfr_pkg::frame_rec_type        push_rec
);

   logic [cvfr_pkg::POS_W-1:0]                               byte_count_ff, byte_count_in;
   logic [cvfr_pkg::CRC_W-1:0]                               crc_ff, crc_in;
   logic [cvfr_pkg::GROUP_W-1:0]                             group_ff, group_in;
   logic [cvfr_pkg::BYTE_W-1:0]                              pec_high_ff, pec_high_in;
   logic [cvfr_pkg::PAYLOAD_LEN-1:0][cvfr_pkg::BYTE_W-1:0]   payload_ff, payload_in;

   logic [cvfr_pkg::POS_W-1:0]   pos;
   logic [cvfr_pkg::CRC_W-1:0]   crc_base;
   logic [cvfr_pkg::CRC_W-1:0]   pec;
   logic                         mismatch;

   always_comb begin
      pos           = frame_start ? cvfr_pkg::POS_FIRST : byte_count_ff;
      crc_base      = (pos == cvfr_pkg::POS_FIRST) ? cvfr_pkg::PEC_SEED : crc_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      group_in      = group_ff;
      pec_high_in   = pec_high_ff;
      payload_in    = payload_ff;
      push          = 1'b0;

      if (accept) begin
         if (pos == cvfr_pkg::POS_FIRST) begin
            group_in = group_index;
         end
         if (pos < cvfr_pkg::POS_PEC_HIGH) begin
            payload_in[pos] = rx_byte;
            crc_in          = cvfr_pkg::pec_byte_step(crc_base, rx_byte);
            byte_count_in   = pos + 3'd1;
         end else if (pos == cvfr_pkg::POS_PEC_HIGH) begin
            pec_high_in   = rx_byte;
            byte_count_in = cvfr_pkg::POS_PEC_LOW;
         end else begin
            byte_count_in = cvfr_pkg::POS_FIRST;
            push          = 1'b1;
         end
      end
   end

   // check on the last byte of the frame
   always_comb begin
      pec      = {crc_ff[cvfr_pkg::CRC_W-2:0], 1'b0};
      mismatch = (pec[15:8] != pec_high_ff) || (pec[7:0] != rx_byte) ||
                 (int'(group_ff) >= cvfr_pkg::NUM_GROUPS);
      push_rec.status = mismatch ? cvfr_pkg::STATUS_PEC_ERROR : cvfr_pkg::STATUS_OK;
      push_rec.group  = group_ff;
      push_rec.raw[0] = {payload_ff[0], payload_ff[1][7:4]};
      push_rec.raw[1] = {payload_ff[1][3:0], payload_ff[2]};
      push_rec.raw[2] = {payload_ff[3], payload_ff[4][7:4]};
      push_rec.raw[3] = {payload_ff[4][3:0], payload_ff[5]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= cvfr_pkg::POS_FIRST;
         crc_ff        <= cvfr_pkg::PEC_SEED;
         group_ff      <= '0;
         pec_high_ff   <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         group_ff      <= group_in;
         pec_high_ff   <= pec_high_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

endmodule

// File: hw/rtl/cvfr_result_queue.sv
module cvfr_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cvfr_pkg::frame_rec_type  push_rec,
   output logic                     full,
   cvfr_rsp_if.source               rsp_chan
);

   cvfr_pkg::frame_rec_type         rec_ff [2];
   cvfr_pkg::frame_rec_type         head;
   logic                            wr_ptr_ff, wr_ptr_in;
   logic                            rd_ptr_ff, rd_ptr_in;
   logic [1:0]                      count_ff, count_in;
   logic [cvfr_pkg::K_W-1:0]        k_ff, k_in;
   logic                            is_err;
   logic                            last;
   logic                            pop;

   always_comb begin
      head   = rec_ff[rd_ptr_ff];
      is_err = (head.status == cvfr_pkg::STATUS_PEC_ERROR);
      last   = is_err || (k_ff == cvfr_pkg::K_W'(cvfr_pkg::READINGS - 1));
      full   = (count_ff == 2'd2);

      rsp_chan.valid         = (count_ff != 2'd0);
      rsp_chan.result_status = head.status;
      rsp_chan.cell_index    = is_err ? '0 : {head.group, k_ff};
      rsp_chan.cell_voltage  = is_err ? '0 : cvfr_pkg::scale_reading(head.raw[k_ff]);
      rsp_chan.last_of_run   = last;

      pop       = rsp_chan.valid && rsp_chan.ready && last;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      k_in      = k_ff;
      if (rsp_chan.valid && rsp_chan.ready) begin
         k_in = last ? '0 : k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         k_ff      <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: hw/rtl/cvfr_checker.sv
`include "cell_voltage_frame_receiver_defines.svh"

module cvfr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_result_status,
   input logic [cvfr_pkg::INDEX_W-1:0]         rsp_cell_index,
   input logic signed [cvfr_pkg::VOLT_W-1:0]   rsp_cell_voltage,
   input logic                                 rsp_last_of_run
);

   // stalled word holds
   `CVFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_index) && $stable(rsp_cell_voltage) && $stable(rsp_last_of_run))

   // error word is a single zeroed word
   `CVFR_ASSERT_IMPLY(a_err_word, rsp_valid && rsp_result_status, rsp_last_of_run && rsp_cell_index == '0 && rsp_cell_voltage == '0)

   // good readings end on the fourth cell of the group
   `CVFR_ASSERT_IMPLY(a_run_end, rsp_valid && !rsp_result_status, rsp_last_of_run == (rsp_cell_index[1:0] == 2'd3))

   // good readings only come from an existing group
   `CVFR_ASSERT_IMPLY(a_cell_range, rsp_valid && !rsp_result_status, int'(rsp_cell_index) < cvfr_pkg::NUM_GROUPS * cvfr_pkg::READINGS)

endmodule

bind cell_voltage_frame_receiver cvfr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_result_status (rsp_chan.result_status),
   .rsp_cell_index    (rsp_chan.cell_index),
   .rsp_cell_voltage  (rsp_chan.cell_voltage),
   .rsp_last_of_run   (rsp_chan.last_of_run)
);

// File: test/testbench.sv
module testbench;
   import cvfr_pkg::*;

   typedef enum int {
      FAULT_NONE,
      FAULT_PEC_LOW,
      FAULT_PEC_HIGH,
      FAULT_PAYLOAD
   } frame_fault_type;

   typedef struct {
      status_type                 status;
      logic [INDEX_W-1:0]         index;
      logic signed [VOLT_W-1:0]   voltage;
      logic                       last;
   } cell_word_type;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   logic clock;
   logic reset;

   cvfr_req_if req_chan();
   cvfr_rsp_if rsp_chan();

   cell_voltage_frame_receiver u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // receiver state as the block should hold it
   logic [POS_W-1:0]   rx_pos;
   logic [14:0]        pec_acc;
   logic [BYTE_W-1:0]  payload [PAYLOAD_LEN];
   logic [BYTE_W-1:0]  pec_high;
   logic [GROUP_W-1:0] group_held;

   cell_word_type expected_cells[$];

   int errors;
   int cells_checked;
   int frames_good;
   int frames_dropped;
   int words_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // bitwise crc15, msb first
   function automatic logic [14:0] crc15_add_byte(input logic [14:0] rem,
                                                  input logic [BYTE_W-1:0] data);
      logic fb;
      for (int i = 0; i < BYTE_W; i++) begin
         fb  = data[BYTE_W-1-i] ^ rem[14];
         rem = {rem[13:0], 1'b0};
         if (fb) begin
            rem = rem ^ PEC_POLY[14:0];
         end
      end
      return rem;
   endfunction

   function automatic logic signed [VOLT_W-1:0] reading_to_volts(input logic [RAW_W-1:0] raw);
      int v;
      int s;
      v = $signed(raw);
      s = (v * 3) / 2;
      return VOLT_W'(s);
   endfunction

   function automatic logic [RAW_W-1:0] pick_reading();
      logic [RAW_W-1:0] r;
      r = RAW_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0: r = 12'h7FF;
            1: r = 12'h800;
            2: r = 12'hFFF;
            3: r = 12'h001;
            4: r = 12'h000;
            default: r = 12'h801;
         endcase
      end
      return r;
   endfunction

   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b, input logic [GROUP_W-1:0] g,
                                 input logic s);
      cell_word_type w;
      logic [RAW_W-1:0] raw [READINGS];
      logic [CRC_W-1:0] pec;
      if (s) begin
         rx_pos = POS_FIRST;
      end
      if (rx_pos == POS_FIRST) begin
         group_held = g;
         pec_acc    = PEC_SEED[14:0];
      end
      if (rx_pos < POS_PEC_HIGH) begin
         payload[rx_pos] = b;
         pec_acc = crc15_add_byte(pec_acc, b);
         rx_pos  = rx_pos + 1'b1;
      end else if (rx_pos == POS_PEC_HIGH) begin
         pec_high = b;
         rx_pos   = POS_PEC_LOW;
      end else begin
         rx_pos = POS_FIRST;
         pec    = {pec_acc, 1'b0};
         if (pec[15:8] != pec_high || pec[7:0] != b || group_held >= NUM_GROUPS) begin
            w.status  = STATUS_PEC_ERROR;
            w.index   = '0;
            w.voltage = '0;
            w.last    = 1'b1;
            expected_cells.push_back(w);
            frames_dropped++;
         end else begin
            raw[0] = {payload[0], payload[1][7:4]};
            raw[1] = {payload[1][3:0], payload[2]};
            raw[2] = {payload[3], payload[4][7:4]};
            raw[3] = {payload[4][3:0], payload[5]};
            for (int k = 0; k < READINGS; k++) begin
               w.status  = STATUS_OK;
               w.index   = INDEX_W'(group_held * 4 + k);
               w.voltage = reading_to_volts(raw[k]);
               w.last    = (k == READINGS - 1);
               expected_cells.push_back(w);
            end
            frames_good++;
         end
      end
   endtask

   task automatic send_word(input logic [BYTE_W-1:0] b, input logic [GROUP_W-1:0] g,
                            input logic s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= b;
      req_chan.group_index <= g;
      req_chan.frame_start <= s;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      decode_rx_byte(b, g, s);
      words_sent++;
   endtask

   task automatic send_frame(input logic [GROUP_W-1:0] grp,
                             input logic [RAW_W-1:0] r0, input logic [RAW_W-1:0] r1,
                             input logic [RAW_W-1:0] r2, input logic [RAW_W-1:0] r3,
                             input logic start, input frame_fault_type fault);
      logic [BYTE_W-1:0] bytes [FRAME_BYTES];
      logic [14:0] acc;
      logic [POS_W-1:0] flip;
      bytes[0] = r0[11:4];
      bytes[1] = {r0[3:0], r1[11:8]};
      bytes[2] = r1[7:0];
      bytes[3] = r2[11:4];
      bytes[4] = {r2[3:0], r3[11:8]};
      bytes[5] = r3[7:0];
      acc = PEC_SEED[14:0];
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         acc = crc15_add_byte(acc, bytes[i]);
      end
      {bytes[6], bytes[7]} = {acc, 1'b0};
      case (fault)
         FAULT_PEC_LOW:  bytes[7] = bytes[7] ^ BYTE_W'(1 << $urandom_range(0, 7));
         FAULT_PEC_HIGH: bytes[6] = bytes[6] ^ BYTE_W'(1 << $urandom_range(0, 7));
         FAULT_PAYLOAD: begin
            flip = POS_W'($urandom_range(0, PAYLOAD_LEN - 1));
            bytes[flip] = bytes[flip] ^ BYTE_W'(1 << $urandom_range(0, 7));
         end
         default: ;
      endcase
      for (int i = 0; i < FRAME_BYTES; i++) begin
         send_word(bytes[i], (i == 0) ? grp : GROUP_W'($urandom), (i == 0) ? start : 1'b0);
      end
   endtask

   task automatic hold_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_cells.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 31;
      recv_idle_pct = 50;
      // full-scale readings, group 0
      send_frame(4'd0, 12'h7FF, 12'h800, 12'hFFF, 12'h001, 1'b1, FAULT_NONE);
      // byte 0 reached by count alone, group beyond the last one
      send_frame(4'd15, 12'h000, 12'h801, 12'h7FE, 12'hFFE, 1'b0, FAULT_NONE);
      // stray bytes, then resync into a frame with a bad pec
      send_word(8'hFF, 4'd3, 1'b1);
      send_word(8'h00, 4'd5, 1'b0);
      send_frame(4'd8, 12'hFFF, 12'h7FF, 12'h800, 12'h000, 1'b1, FAULT_PEC_LOW);
   endtask

   task automatic test_random_phase(input int words, input int s_pct, input int r_pct,
                                    input bit hold_midway);
      int target;
      int kind;
      int n;
      bit hold_pending;
      logic start;
      logic [GROUP_W-1:0] grp;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      target = words_sent + words;
      hold_pending = hold_midway;
      while (words_sent < target) begin
         if (hold_pending && words_sent >= target - words / 2) begin
            hold_for_results();
            hold_pending = 1'b0;
         end
         kind  = $urandom_range(0, 99);
         start = (rx_pos == POS_FIRST) ? 1'($urandom_range(0, 1)) : 1'b1;
         grp   = GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
         if (kind < 70) begin
            send_frame(grp, pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                       start, FAULT_NONE);
         end else if (kind < 82) begin
            send_frame(grp, pick_reading(), pick_reading(), pick_reading(), pick_reading(),
                       start, frame_fault_type'($urandom_range(1, 3)));
         end else if (kind < 90) begin
            send_frame(GROUP_W'($urandom_range(NUM_GROUPS, 15)), pick_reading(),
                       pick_reading(), pick_reading(), pick_reading(), start, FAULT_NONE);
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               send_word(BYTE_W'($urandom), GROUP_W'($urandom),
                         1'($urandom_range(0, 99) < 30));
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_cells
      cell_word_type w;
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected word status=%0d index=%0d voltage=%0d last=%0d",
                     $time, rsp_chan.result_status, rsp_chan.cell_index,
                     rsp_chan.cell_voltage, rsp_chan.last_of_run);
            errors++;
         end else begin
            w = expected_cells.pop_front();
            if (rsp_chan.result_status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status,
                        rsp_chan.result_status);
               errors++;
            end
            if (rsp_chan.cell_index !== w.index) begin
               $display("%0t: cell index expected %0d actual %0d", $time, w.index,
                        rsp_chan.cell_index);
               errors++;
            end
            if (rsp_chan.cell_voltage !== w.voltage) begin
               $display("%0t: cell voltage expected %0d actual %0d", $time, w.voltage,
                        rsp_chan.cell_voltage);
               errors++;
            end
            if (rsp_chan.last_of_run !== w.last) begin
               $display("%0t: last flag expected %0d actual %0d", $time, w.last,
                        rsp_chan.last_of_run);
               errors++;
            end
            cells_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (expected_cells.size() == 0 && !req_chan.valid)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d words still expected", $time,
                  stall_cycles, expected_cells.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      frames_good    = 0;
      frames_dropped = 0;
      words_sent     = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      rx_pos         = POS_FIRST;
      pec_acc        = PEC_SEED[14:0];
      pec_high       = '0;
      group_held     = '0;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.rx_byte     <= '0;
      req_chan.group_index <= '0;
      req_chan.frame_start <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(82, 31, 50, 1'b1);
      test_random_phase(82, 50, 31, 1'b0);
      test_random_phase(82, 0, 0, 1'b0);

      req_chan.valid <= 1'b0;
      while (expected_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d frame words: %0d frames decoded, %0d frames dropped", words_sent,
               frames_good, frames_dropped);
      $display("checked %0d result words across three stall patterns", cells_checked);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cvfr_pkg.sv
hw/rtl/cvfr_req_if.sv
hw/rtl/cvfr_rsp_if.sv
hw/rtl/cvfr_frame_unpack.sv
hw/rtl/cvfr_result_queue.sv
hw/rtl/cell_voltage_frame_receiver.sv
hw/rtl/cvfr_checker.sv
test/testbench.sv
